// ----- src/svoc_pkg.sv -----
`timescale 1ns / 1ps

package svoc_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 6;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_in_beat;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_res;
        logic [COUNT_W-1:0]        count;
        logic                      last_res;
        logic                      overflow;
    } t_out_beat;

    typedef struct packed {
        logic start;
        logic overflow;
    } t_scan_ctrl;

endpackage

// ----- src/sorted_value_occurrence_counter_unit.sv -----
`timescale 1ns / 1ps

// Collects a set of signed values, one input beat per cycle, and reports
// the distinct values in descending order with their occurrence counts.
// An input beat moves when i_in_valid is high and o_in_stall is low; an
// output beat moves when o_out_valid is high and i_out_stall is low.
// Up to DEPTH values are stored; later beats of the same set are dropped
// and every result of that set carries the overflow flag.
// While a set is being collected, one beat is taken every cycle. After the
// beat marked last, o_in_stall stays high while the results are produced.
// Each result takes one full scan of the stored values through a single
// compare unit and the value memory read port. The final result carries
// last_res. A result waits in the output register while the receiver
// stalls; the next result is scanned meanwhile and is loaded once that
// register is free. Input is accepted again once the last result has been
// loaded. Reset empties the store and clears the overflow flag and output
// valid.
module sorted_value_occurrence_counter_unit #(
    parameter int DEPTH = svoc_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  svoc_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output svoc_pkg::t_out_beat o_out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]        r_fill;
    logic                 r_ovf;
    logic                 r_busy;
    logic                 in_acc;
    logic                 has_room;
    logic                 done;
    svoc_pkg::t_scan_ctrl ctrl;

    assign in_acc        = i_in_valid && !r_busy;
    assign has_room      = (r_fill < CW'(DEPTH));
    assign ctrl.start    = in_acc && i_in_data.last;
    assign ctrl.overflow = r_ovf || (in_acc && !has_room);
    assign o_in_stall    = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_ovf  <= 1'b0;
            r_busy <= 1'b0;
        end else if (done) begin
            r_fill <= '0;
            r_ovf  <= 1'b0;
            r_busy <= 1'b0;
        end else if (in_acc) begin
            if (has_room) begin
                r_fill <= r_fill + 1'b1;
            end else begin
                r_ovf <= 1'b1;
            end
            if (i_in_data.last) begin
                r_busy <= 1'b1;
            end
        end
    end

    svoc_scan #(
        .DEPTH(DEPTH),
        .AW   (AW),
        .CW   (CW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (in_acc && has_room),
        .i_wr_addr  (r_fill[AW-1:0]),
        .i_wr_data  (i_in_data.value),
        .i_ctrl     (ctrl),
        .i_fill     (r_fill),
        .o_done     (done),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

endmodule

// ----- src/svoc_scan.sv -----
`timescale 1ns / 1ps

module svoc_scan #(
    parameter int DEPTH = svoc_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic [AW-1:0]                     i_wr_addr,
    input  logic signed [svoc_pkg::VALUE_W-1:0] i_wr_data,
    input  svoc_pkg::t_scan_ctrl              i_ctrl,
    input  logic [CW-1:0]                     i_fill,
    output logic                              o_done,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output svoc_pkg::t_out_beat               o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    logic signed [svoc_pkg::VALUE_W-1:0] r_mem [DEPTH];

    t_state                              r_state, n_state;
    logic [CW-1:0]                       r_idx, n_idx;
    logic                                r_rd_vld, n_rd_vld;
    logic                                r_rd_end, n_rd_end;
    logic signed [svoc_pkg::VALUE_W-1:0] r_rd_data;
    logic                                r_has_thr, n_has_thr;
    logic signed [svoc_pkg::VALUE_W-1:0] r_thr, n_thr;
    logic                                r_found, n_found;
    logic signed [svoc_pkg::VALUE_W-1:0] r_best, n_best;
    logic [CW-1:0]                       r_cnt, n_cnt;
    logic [CW-1:0]                       r_done_cnt, n_done_cnt;
    logic                                r_ovf, n_ovf;
    logic                                r_out_valid, n_out_valid;
    svoc_pkg::t_out_beat                 r_out, n_out;
    logic                                rd_en;
    logic                                out_free;
    logic                                set_end;
    logic [CW:0]                         emitted;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign emitted  = {1'b0, r_done_cnt} + {1'b0, r_cnt};
    assign set_end  = (emitted == {1'b0, i_fill});

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_rd_vld    = 1'b0;
        n_rd_end    = 1'b0;
        n_has_thr   = r_has_thr;
        n_thr       = r_thr;
        n_found     = r_found;
        n_best      = r_best;
        n_cnt       = r_cnt;
        n_done_cnt  = r_done_cnt;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        rd_en       = 1'b0;
        o_done      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_ctrl.start) begin
                    n_state    = S_SCAN;
                    n_idx      = '0;
                    n_has_thr  = 1'b0;
                    n_found    = 1'b0;
                    n_cnt      = '0;
                    n_done_cnt = '0;
                    n_ovf      = i_ctrl.overflow;
                end
            end
            S_SCAN: begin
                if (r_idx < i_fill) begin
                    rd_en    = 1'b1;
                    n_idx    = r_idx + 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_end = (r_idx == i_fill - 1'b1);
                end
                if (r_rd_vld) begin
                    if (!r_has_thr || (r_rd_data < r_thr)) begin
                        if (!r_found || (r_rd_data > r_best)) begin
                            n_found = 1'b1;
                            n_best  = r_rd_data;
                            n_cnt   = CW'(1);
                        end else if (r_rd_data == r_best) begin
                            n_cnt = r_cnt + 1'b1;
                        end
                    end
                    if (r_rd_end) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.value_res   = r_best;
                    n_out.count       = r_cnt[svoc_pkg::COUNT_W-1:0];
                    n_out.last_res    = set_end;
                    n_out.overflow    = r_ovf;
                    n_done_cnt        = emitted[CW-1:0];
                    if (set_end) begin
                        n_state = S_IDLE;
                        o_done  = 1'b1;
                    end else begin
                        n_state   = S_SCAN;
                        n_idx     = '0;
                        n_has_thr = 1'b1;
                        n_thr     = r_best;
                        n_found   = 1'b0;
                        n_cnt     = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_vld    <= 1'b0;
            r_rd_end    <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_has_thr   <= 1'b0;
            r_found     <= 1'b0;
            r_cnt       <= '0;
            r_done_cnt  <= '0;
            r_ovf       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_vld    <= n_rd_vld;
            r_rd_end    <= n_rd_end;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_has_thr   <= n_has_thr;
            r_found     <= n_found;
            r_cnt       <= n_cnt;
            r_done_cnt  <= n_done_cnt;
            r_ovf       <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_thr  <= n_thr;
        r_best <= n_best;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- bench/svoc_occurrence_checker.sv -----
`timescale 1ns / 1ps

module svoc_occurrence_checker #(
    parameter int DEPTH = svoc_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  svoc_pkg::t_in_beat  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  svoc_pkg::t_out_beat i_out_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    logic signed [svoc_pkg::VALUE_W-1:0] held_values [DEPTH];
    int                                  held_count   = 0;
    logic                                dropped_seen = 1'b0;
    svoc_pkg::t_out_beat                 expected_tallies [$];
    int                                  fail_total   = 0;

    function automatic int field_differs(string name, longint expv, longint actv);
        if (expv == actv) begin
            return 0;
        end
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
        return 1;
    endfunction

    // Sorts the held set into descending signed order and queues one beat per
    // distinct value, then empties the store for the next set.
    task automatic tally_sorted_set();
        logic signed [svoc_pkg::VALUE_W-1:0] key;
        int                                  j;
        int                                  run;
        svoc_pkg::t_out_beat                 tally;
        for (int i = 1; i < held_count; i++) begin
            key = held_values[i];
            j = i;
            while (j > 0 && key > held_values[j-1]) begin
                held_values[j] = held_values[j-1];
                j--;
            end
            held_values[j] = key;
        end
        run = 0;
        tally = '0;
        tally.overflow = dropped_seen;
        for (int i = 0; i < held_count; i++) begin
            if (run != 0 && held_values[i] == tally.value_res) begin
                run++;
            end else begin
                if (run != 0) begin
                    tally.count = run[svoc_pkg::COUNT_W-1:0];
                    tally.last_res = 1'b0;
                    expected_tallies.insert(expected_tallies.size(), tally);
                end
                tally.value_res = held_values[i];
                run = 1;
            end
        end
        if (run != 0) begin
            tally.count = run[svoc_pkg::COUNT_W-1:0];
            tally.last_res = 1'b1;
            expected_tallies.insert(expected_tallies.size(), tally);
        end
        held_count = 0;
        dropped_seen = 1'b0;
    endtask

    always @(posedge i_clk) begin
        svoc_pkg::t_out_beat exp_beat;
        int                  errs;
        if (!i_rst_n) begin
            held_count = 0;
            dropped_seen = 1'b0;
            expected_tallies.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_tallies.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %0d x%0d %b %b",
                             $time, i_out_data.value_res, i_out_data.count,
                             i_out_data.last_res, i_out_data.overflow);
                    fail_total++;
                end else begin
                    exp_beat = expected_tallies.pop_front();
                    errs = field_differs("value_res", longint'(exp_beat.value_res),
                                         longint'(i_out_data.value_res))
                         + field_differs("count", longint'(exp_beat.count),
                                         longint'(i_out_data.count))
                         + field_differs("last_res", longint'(exp_beat.last_res),
                                         longint'(i_out_data.last_res))
                         + field_differs("overflow", longint'(exp_beat.overflow),
                                         longint'(i_out_data.overflow));
                    fail_total += errs;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (held_count < DEPTH) begin
                    held_values[held_count] = i_in_data.value;
                    held_count++;
                end else begin
                    dropped_seen = 1'b1;
                end
                if (i_in_data.last) begin
                    tally_sorted_set();
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending <= expected_tallies.size();
    end

endmodule

// ----- bench/tb_sorted_value_occurrence_counter_unit.sv -----
`timescale 1ns / 1ps

module tb_sorted_value_occurrence_counter_unit;

    localparam int          DEPTH       = svoc_pkg::DEPTH_DEF;
    localparam int          ITEM_TARGET = 300;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    localparam logic signed [svoc_pkg::VALUE_W-1:0] MAX_V = 32'sh7FFF_FFFF;
    localparam logic signed [svoc_pkg::VALUE_W-1:0] MIN_V = 32'sh8000_0000;

    typedef enum int {
        SHAPE_DUPS,
        SHAPE_WIDE,
        SHAPE_MEDIUM,
        SHAPE_FULL,
        SHAPE_OVERFLOW,
        SHAPE_EXTREMES,
        SHAPE_COUNT
    } t_set_shape;

    typedef enum int {
        FLAVOR_CLUSTER,
        FLAVOR_EXTREME,
        FLAVOR_ANY
    } t_value_flavor;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    svoc_pkg::t_in_beat  in_data   = '0;
    logic                out_stall = 1'b0;
    logic                in_stall;
    logic                out_valid;
    svoc_pkg::t_out_beat out_data;
    int                  fail_count;
    int                  pending;
    int unsigned         cycle_count = 0;
    int                  burst_left  = 0;
    int                  items_sent  = 0;
    t_stall_mode         stall_mode  = STALL_NONE;
    int                  stall_span  = 0;

    sorted_value_occurrence_counter_unit #(
        .DEPTH (DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    svoc_occurrence_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sorted_value_occurrence_counter_unit test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_span <= $urandom_range(20, 200);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            STALL_NONE: begin
                out_stall <= 1'b0;
            end
            STALL_LIGHT: begin
                out_stall <= ($urandom_range(0, 3) == 0);
            end
            STALL_HEAVY: begin
                out_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                out_stall <= cycle_count[2];
            end
        endcase
    end

    function automatic logic signed [svoc_pkg::VALUE_W-1:0] draw_value(t_value_flavor flavor);
        case (flavor)
            FLAVOR_CLUSTER: begin
                return int'($urandom_range(0, 6)) - 3;
            end
            FLAVOR_EXTREME: begin
                case ($urandom_range(0, 6))
                    0: return MIN_V;
                    1: return 32'sh8000_0001;
                    2: return -1;
                    3: return 0;
                    4: return 1;
                    5: return 32'sh7FFF_FFFE;
                    default: return MAX_V;
                endcase
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    // Each beat may be preceded by an idle gap when the current burst runs out.
    task automatic send_beat(input logic signed [svoc_pkg::VALUE_W-1:0] v, input logic l);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data.value <= v;
        in_data.last <= l;
        do @(posedge i_clk); while (in_stall);
        items_sent++;
    endtask

    task automatic send_set(input t_set_shape shape);
        int                                  n;
        bit                                  uniform;
        logic signed [svoc_pkg::VALUE_W-1:0] fixed_v;
        t_value_flavor                       flavor;
        logic signed [svoc_pkg::VALUE_W-1:0] v;
        uniform = 1'b0;
        fixed_v = draw_value(t_value_flavor'($urandom_range(0, 2)));
        case (shape)
            SHAPE_DUPS:     n = $urandom_range(1, 8);
            SHAPE_WIDE:     n = $urandom_range(1, 8);
            SHAPE_MEDIUM:   n = $urandom_range(9, DEPTH - 1);
            SHAPE_FULL: begin
                n = DEPTH;
                uniform = ($urandom_range(0, 2) == 0);
            end
            SHAPE_OVERFLOW: n = $urandom_range(DEPTH + 1, DEPTH + 8);
            default:        n = $urandom_range(1, 10);
        endcase
        for (int i = 0; i < n; i++) begin
            case (shape)
                SHAPE_DUPS:     flavor = FLAVOR_CLUSTER;
                SHAPE_WIDE:     flavor = FLAVOR_ANY;
                SHAPE_EXTREMES: flavor = FLAVOR_EXTREME;
                default:        flavor = t_value_flavor'($urandom_range(0, 2));
            endcase
            v = uniform ? fixed_v : draw_value(flavor);
            send_beat(v, i == n - 1);
        end
    endtask

    initial begin
        int set_idx;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(MAX_V, 1'b1);
        send_beat(MIN_V, 1'b1);
        send_beat(0, 1'b0);
        send_beat(-1, 1'b0);
        send_beat(1, 1'b0);
        send_beat(MIN_V, 1'b0);
        send_beat(MAX_V, 1'b0);
        send_beat(MIN_V, 1'b0);
        send_beat(-1, 1'b1);
        send_beat(7, 1'b0);
        send_beat(7, 1'b0);
        send_beat(7, 1'b0);
        send_beat(7, 1'b1);
        send_beat(MAX_V, 1'b0);
        send_beat(MAX_V, 1'b1);

        set_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            send_set(t_set_shape'(set_idx % SHAPE_COUNT));
            set_idx++;
        end
        in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("sorted_value_occurrence_counter_unit test passed");
        end else begin
            $display("sorted_value_occurrence_counter_unit test failed");
        end
        $finish;
    end

endmodule
